// ===== sv/sle_pkg.sv =====
// sle_pkg: shared constants, operation and status codes, cell command type
// and prefix helpers for the sorted list engine
// no dependencies
`default_nettype none
package sle_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int FUNC_BITS  = 3;
  localparam int STAT_BITS  = 2;

  localparam int IN_BITS    = FUNC_BITS + VALUE_BITS + IDX_BITS;
  localparam int IN_BYTES   = (IN_BITS + 7) / 8;
  localparam int OUT_BITS   = VALUE_BITS + CNT_BITS + STAT_BITS + CNT_BITS;
  localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;

  localparam logic [FUNC_BITS-1:0] FN_INSERT     = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_REMOVE     = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_READ       = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_FIND_FIRST = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_FIND_LAST  = 3'd4;

  localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_BAD_POS   = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [CNT_BITS-1:0] NO_POS  = CNT_BITS'(CAPACITY);
  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(CAPACITY);

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic                 cmp_en;
    logic                 ins_en;
    logic                 rem_en;
    logic [FUNC_BITS-1:0] func;
    logic                 descending;
    logic [CNT_BITS-1:0]  count;
    logic [IDX_BITS-1:0]  pos;
    value_t               value;
  } cell_cmd_t;

  // or of all flags strictly below each bit, log-depth
  function automatic logic [CAPACITY-1:0] prefix_below(input logic [CAPACITY-1:0] f);
    logic [CAPACITY-1:0] p;
    p = f;
    for (int s = 1; s < CAPACITY; s = s * 2) begin
      p = p | (p << s);
    end
    return p << 1;
  endfunction

  // or of all flags strictly above each bit, log-depth
  function automatic logic [CAPACITY-1:0] prefix_above(input logic [CAPACITY-1:0] f);
    logic [CAPACITY-1:0] p;
    p = f;
    for (int s = 1; s < CAPACITY; s = s * 2) begin
      p = p | (p >> s);
    end
    return p >> 1;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sle_cell.sv =====
// sle_cell: one list entry with its match flag; compares against the
// broadcast value and shifts to or from its neighbors; uses sle_pkg
`default_nettype none
module sle_cell
  import sle_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [IDX_BITS-1:0] idx,
  input  wire cell_cmd_t           cmd,
  input  wire value_t              left,
  input  wire value_t              right,
  input  wire logic                hit,
  input  wire logic                pre,
  output value_t                   value,
  output logic                     flag
);

  logic in_list;
  logic goes_before;
  logic flag_next;

  assign in_list     = {1'b0, idx} < cmd.count;
  assign goes_before = cmd.descending ? (cmd.value >= value) : (cmd.value <= value);

  always_comb begin
    case (cmd.func)
      FN_INSERT:                   flag_next = !in_list || goes_before;
      FN_REMOVE, FN_READ:          flag_next = idx == cmd.pos;
      FN_FIND_FIRST, FN_FIND_LAST: flag_next = in_list && (cmd.value == value);
      default:                     flag_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      flag <= flag_next;
    end
    if (cmd.ins_en) begin
      if (hit) begin
        value <= cmd.value;
      end else if (pre) begin
        value <= left;
      end
    end else if (cmd.rem_en && (hit || pre)) begin
      value <= right;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sle_scan.sv =====
// sle_scan: picks the first or last raised flag of the cell row and
// encodes its position; uses sle_pkg
`default_nettype none
module sle_scan
  import sle_pkg::*;
(
  input  wire logic [CAPACITY-1:0] flags,
  input  wire logic                last_mode,
  output logic [CAPACITY-1:0]      sel,
  output logic [CAPACITY-1:0]      pre,
  output logic                     any_hit,
  output logic [IDX_BITS-1:0]      index
);

  logic [CAPACITY-1:0] above;

  assign pre     = prefix_below(flags);
  assign above   = prefix_above(flags);
  assign sel     = last_mode ? (flags & ~above) : (flags & ~pre);
  assign any_hit = |flags;

  always_comb begin
    index = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      index = index | ({IDX_BITS{sel[i]}} & IDX_BITS'(i));
    end
  end

endmodule
`default_nettype wire

// ===== sv/sorted_list_engine.sv =====
// sorted_list_engine: top level, row of list cells, scan unit, control,
// output register and configuration port; uses sle_pkg, sle_cell, sle_scan
//
// channel  direction  transaction
// s_t*     in         func, item_value, item_position
// m_t*     out        result_value, result_position, status, element_count
// p*       in/out     descending_order register at byte address 0
//
// each item runs as a compare in every cell, then the scan of the
// match flags with the shift of the cell row
// the next item is taken after the result enters the output register;
// a stalled output holds the scan and shift step until the register frees
// rst clears the count, the order bit and the handshake state
`default_nettype none
module sorted_list_engine
  import sle_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_BYTES*8-1:0]  s_tdata,   // func, item_value, item_position
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_BYTES*8-1:0]      m_tdata,   // result_value, result_position, status,
                                                 // element_count
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                  state;
  logic                  descending;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic [FUNC_BITS-1:0]  op_func;
  value_t                op_value;
  logic [IDX_BITS-1:0]   op_pos;

  logic [FUNC_BITS-1:0]  in_func;
  value_t                in_value;
  logic [IDX_BITS-1:0]   in_pos;
  logic                  accept;
  logic                  fire;

  cell_cmd_t             cmd;
  value_t                cell_val [CAPACITY];
  logic [CAPACITY-1:0]   flags;
  logic [CAPACITY-1:0]   sel;
  logic [CAPACITY-1:0]   pre;
  logic                  any_hit;
  logic [IDX_BITS-1:0]   hit_index;

  value_t                sel_value;
  value_t                res_value;
  logic [CNT_BITS-1:0]   res_pos;
  logic [STAT_BITS-1:0]  res_status;
  logic                  do_ins;
  logic                  do_rem;
  logic                  pos_bad;

  assign in_func  = s_tdata[FUNC_BITS-1:0];
  assign in_value = s_tdata[FUNC_BITS +: VALUE_BITS];
  assign in_pos   = s_tdata[FUNC_BITS+VALUE_BITS +: IDX_BITS];

  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign fire     = (state == ST_BUSY) && (!m_tvalid || m_tready);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, descending} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      descending <= pwdata[0];
    end
  end

  // cell row
  always_comb begin
    cmd.cmp_en     = accept;
    cmd.ins_en     = fire && do_ins;
    cmd.rem_en     = fire && do_rem;
    cmd.func       = accept ? in_func : op_func;
    cmd.descending = descending;
    cmd.count      = count;
    cmd.pos        = accept ? in_pos : op_pos;
    cmd.value      = accept ? in_value : op_value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_val;
    value_t right_val;
    if (i == 0) begin : g_first
      assign left_val = cell_val[i];
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end
    sle_cell u_cell (
      .clk   (clk),
      .idx   (IDX_BITS'(i)),
      .cmd   (cmd),
      .left  (left_val),
      .right (right_val),
      .hit   (sel[i]),
      .pre   (pre[i]),
      .value (cell_val[i]),
      .flag  (flags[i])
    );
  end

  sle_scan u_scan (
    .flags     (flags),
    .last_mode (op_func == FN_FIND_LAST),
    .sel       (sel),
    .pre       (pre),
    .any_hit   (any_hit),
    .index     (hit_index)
  );

  always_comb begin
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_value = sel_value | ({VALUE_BITS{sel[i]}} & cell_val[i]);
    end
  end

  // result of the operation in flight
  assign pos_bad = {1'b0, op_pos} >= count;

  always_comb begin
    res_value  = '0;
    res_pos    = NO_POS;
    res_status = ST_OK;
    count_next = count;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    case (op_func)
      FN_INSERT: begin
        if (count == CNT_MAX) begin
          res_status = ST_FULL;
        end else begin
          res_pos    = {1'b0, hit_index};
          count_next = count + 1'b1;
          do_ins     = 1'b1;
        end
      end
      FN_REMOVE, FN_READ: begin
        if (pos_bad) begin
          res_status = ST_BAD_POS;
        end else begin
          res_value = sel_value;
          res_pos   = {1'b0, op_pos};
          if (op_func == FN_REMOVE) begin
            count_next = count - 1'b1;
            do_rem     = 1'b1;
          end
        end
      end
      FN_FIND_FIRST, FN_FIND_LAST: begin
        if (any_hit) begin
          res_pos = {1'b0, hit_index};
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        state <= ST_BUSY;
      end else if (fire) begin
        state <= ST_IDLE;
      end
      if (fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func  <= in_func;
      op_value <= in_value;
      op_pos   <= in_pos;
    end
    if (fire) begin
      m_tdata <= (OUT_BYTES*8)'({count_next, res_status, res_pos, res_value});
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("element count above capacity");

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUSY |-> $onehot0(sel))
    else $error("more than one cell selected");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    fire && op_func == FN_INSERT && count != CNT_MAX |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the list");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_BUSY && !s_tready)
    else $error("accepted item not in flight");

  a_insert_hit: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUSY && op_func == FN_INSERT && count != CNT_MAX |-> any_hit)
    else $error("insert found no slot");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for sorted_list_engine; drives operations on the
// stream input, checks every result against a shadow copy of the list, and
// flips the order register over apb between phases; needs sle_pkg and the rtl
module tb import sle_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [FUNC_BITS-1:0] func_t;
  typedef logic [IDX_BITS-1:0]  pos_t;

  // lowest field first: value, position, status, count
  typedef struct packed {
    logic [CNT_BITS-1:0]  count;
    logic [STAT_BITS-1:0] status;
    logic [CNT_BITS-1:0]  position;
    value_t               value;
  } reply_t;

  typedef enum {GROW, CHURN, SHRINK} style_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RHYTHM} rx_mode_t;

  localparam func_t      FN_FIRST_UNUSED = FN_FIND_LAST + 3'd1;
  localparam logic [2:0] REG_ORDER       = 3'd0;
  localparam value_t     VAL_MAX = value_t'({1'b0, {(VALUE_BITS-1){1'b1}}});
  localparam value_t     VAL_MIN = value_t'({1'b1, {(VALUE_BITS-1){1'b0}}});

  class list_scoreboard;
    value_t      cells[CAPACITY];
    int unsigned fill;
    bit          descending;
    reply_t      awaited[$];
    int unsigned errors;
    int unsigned peak_fill;
    int unsigned op_seen[8];
    int unsigned status_seen[4];

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
    endfunction

    function void note_op(func_t f, value_t v, pos_t p);
      reply_t r;
      int     i;
      r.value    = '0;
      r.position = NO_POS;
      r.status   = ST_OK;
      case (f)
        FN_INSERT: begin
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            i = 0;
            while (i < int'(fill) && !(descending ? v >= cells[i] : v <= cells[i])) i++;
            for (int j = int'(fill); j > i; j--) cells[j] = cells[j-1];
            cells[i] = v;
            fill++;
            r.position = CNT_BITS'(i);
          end
        end
        FN_REMOVE, FN_READ: begin
          if (p >= fill) begin
            r.status = ST_BAD_POS;
          end else begin
            r.value    = cells[p];
            r.position = CNT_BITS'(p);
            if (f == FN_REMOVE) begin
              for (int j = int'(p); j < int'(fill) - 1; j++) cells[j] = cells[j+1];
              fill--;
            end
          end
        end
        FN_FIND_FIRST: begin
          r.status = ST_NOT_FOUND;
          for (int j = 0; j < int'(fill); j++) begin
            if (cells[j] == v) begin
              r.position = CNT_BITS'(j);
              r.status   = ST_OK;
              break;
            end
          end
        end
        FN_FIND_LAST: begin
          r.status = ST_NOT_FOUND;
          for (int j = int'(fill) - 1; j >= 0; j--) begin
            if (cells[j] == v) begin
              r.position = CNT_BITS'(j);
              r.status   = ST_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      r.count = CNT_BITS'(fill);
      if (fill > peak_fill) peak_fill = fill;
      op_seen[f]++;
      status_seen[r.status]++;
      awaited.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      if (got.value !== want.value) report("result_value", want.value, got.value);
      if (got.position !== want.position)
        report("result_position", want.position, got.position);
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.count !== want.count) report("element_count", want.count, got.count);
    endfunction
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_BYTES*8-1:0]  s_tdata  = '0;   // func, item_value, item_position
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_BYTES*8-1:0] m_tdata;         // result_value, result_position, status,
                                           // element_count
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [2:0]             paddr    = '0;
  logic [31:0]            pwdata   = '0;
  logic [31:0]            prdata;
  logic                   pready;

  list_scoreboard sb = new;
  int unsigned    burst_left = 0;
  value_t         pool[8];
  rx_mode_t       rx_mode = RX_OPEN;
  int unsigned    rx_tick = 0;

  sorted_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(reply_t'(m_tdata));
    rx_tick <= rx_tick + 1;
    if (rx_tick % 150 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 2));
    case (rx_mode)
      RX_OPEN:  m_tready <= 1'b1;
      RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
      default:  m_tready <= (rx_tick % 7) < 3;
    endcase
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.awaited.size());
    $display("status: fail");
    $finish;
  end

  task automatic send_op(func_t f, value_t v, pos_t p);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_BYTES*8-IN_BITS){1'b0}}, p, v, f};
    do @(posedge clk); while (!s_tready);
    sb.note_op(f, v, p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 4);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(bit desc);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_ORDER;
    pwdata  <= ($urandom() & ~32'd1) | 32'(desc);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== desc) sb.report("descending_order", desc, prdata[0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.descending = desc;
  endtask

  task automatic random_op(style_t style);
    func_t       f;
    value_t      v;
    pos_t        p;
    int unsigned roll;
    int unsigned w_ins, w_rem, w_rd, w_ff, w_fl;
    case (style)
      GROW:    begin w_ins = 70; w_rem = 8;  w_rd = 8;  w_ff = 6; w_fl = 6; end
      CHURN:   begin w_ins = 35; w_rem = 25; w_rd = 15; w_ff = 10; w_fl = 10; end
      default: begin w_ins = 15; w_rem = 55; w_rd = 10; w_ff = 8; w_fl = 7; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < w_ins) f = FN_INSERT;
    else if (roll < w_ins + w_rem) f = FN_REMOVE;
    else if (roll < w_ins + w_rem + w_rd) f = FN_READ;
    else if (roll < w_ins + w_rem + w_rd + w_ff) f = FN_FIND_FIRST;
    else if (roll < w_ins + w_rem + w_rd + w_ff + w_fl) f = FN_FIND_LAST;
    else f = func_t'($urandom_range(FN_FIRST_UNUSED, {FUNC_BITS{1'b1}}));
    if ((f == FN_FIND_FIRST || f == FN_FIND_LAST) && sb.fill > 0 &&
        $urandom_range(0, 99) < 70)
      v = sb.cells[$urandom_range(0, sb.fill - 1)];
    else if ($urandom_range(0, 99) < 60)
      v = pool[$urandom_range(0, 7)];
    else
      v = value_t'($urandom());
    if (sb.fill > 0 && $urandom_range(0, 99) < 80)
      p = pos_t'($urandom_range(0, sb.fill - 1));
    else
      p = pos_t'($urandom_range(0, CAPACITY - 1));
    send_op(f, v, p);
  endtask

  initial begin
    bit     phase_desc[6]  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    style_t phase_style[6] = '{GROW, CHURN, SHRINK, CHURN, GROW, SHRINK};
    int     phase_len[6]   = '{130, 110, 100, 110, 110, 90};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_order(1'b0);

    // empty list, then duplicates and both extremes
    send_op(FN_READ, 0, pos_t'(0));
    send_op(FN_REMOVE, 0, pos_t'(CAPACITY - 1));
    send_op(FN_FIND_FIRST, 5, pos_t'(0));
    send_op(FN_FIND_LAST, -5, pos_t'(0));
    send_op(FN_INSERT, VAL_MAX, pos_t'(0));
    send_op(FN_INSERT, VAL_MIN, pos_t'(0));
    send_op(FN_INSERT, 0, pos_t'(0));
    send_op(FN_INSERT, -1, pos_t'(0));
    send_op(FN_INSERT, 0, pos_t'(0));
    send_op(FN_INSERT, VAL_MAX, pos_t'(0));
    send_op(FN_FIND_FIRST, 0, pos_t'(0));
    send_op(FN_FIND_LAST, 0, pos_t'(0));
    send_op(FN_FIND_FIRST, VAL_MAX, pos_t'(0));
    send_op(FN_FIND_LAST, VAL_MIN, pos_t'(0));
    send_op(FN_FIND_FIRST, 12345, pos_t'(0));
    send_op(FN_READ, 0, pos_t'(0));
    send_op(FN_READ, 0, pos_t'(5));
    send_op(FN_READ, 0, pos_t'(6));
    send_op(FN_READ, 0, pos_t'(CAPACITY - 1));
    send_op(FN_REMOVE, 0, pos_t'(2));
    send_op(FN_REMOVE, 0, pos_t'(0));
    for (int k = 0; k < 3; k++)
      send_op(func_t'(FN_FIRST_UNUSED + k), -1, pos_t'(CAPACITY - 1));

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      set_order(phase_desc[ph]);
      pool[0] = VAL_MAX;
      pool[1] = VAL_MIN;
      pool[2] = 0;
      pool[3] = -1;
      for (int k = 4; k < 8; k++)
        pool[k] = (ph % 2) ? value_t'($urandom()) : value_t'($urandom_range(0, 20) - 10);
      for (int n = 0; n < phase_len[ph]; n++) begin
        if (n == phase_len[ph] / 2) wait_drained();
        random_op(phase_style[ph]);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d inserts, %0d removes, %0d reads, %0d finds, %0d unused codes",
             sb.op_seen[FN_INSERT], sb.op_seen[FN_REMOVE], sb.op_seen[FN_READ],
             sb.op_seen[FN_FIND_FIRST] + sb.op_seen[FN_FIND_LAST],
             sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7]);
    $display("outcomes: %0d ok, %0d full, %0d bad position, %0d not found, peak fill %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_BAD_POS],
             sb.status_seen[ST_NOT_FOUND], sb.peak_fill);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
